/* sv/f2h_pkg.sv */
// Package for the binary32 to binary16 converter.
// Holds field widths, bit-pattern constants and exponent thresholds.
// No dependencies.
package f2h_pkg;

  localparam int unsigned SGL_W  = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned FRAC_W = 23;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned SH_W   = 5;
  localparam int unsigned MAN_W  = 10;

  localparam logic [15:0] HALF_EXP_ONE = 16'h0400;
  localparam logic [15:0] HALF_SIGN    = 16'h8000;
  localparam logic [14:0] HALF_INF     = 15'h7C00;
  localparam logic [15:0] HALF_QUIET   = 16'h0200;

  // Single exponent fields (biased) that bound each conversion range.
  localparam logic [7:0] EXP_ROUND_ONLY = 8'd102;  // half of the smallest subnormal
  localparam logic [7:0] EXP_SUB_LO     = 8'd103;  // first subnormal result
  localparam logic [7:0] EXP_NORM_LO    = 8'd113;  // first normal result
  localparam logic [7:0] EXP_NORM_HI    = 8'd142;  // last normal result
  localparam logic [7:0] EXP_SPECIAL    = 8'd255;  // infinity or NaN
  localparam logic [7:0] SUB_SH_BASE    = 8'd113;  // base shift for subnormals
  localparam logic [7:0] SUB_FRAC_BASE  = 8'd126;  // fraction shift for subnormals
  localparam logic [7:0] NORM_EXP_BIAS  = 8'd112;  // rebias to the half exponent

  localparam logic [4:0] SH_NORMAL = 5'd13;
  localparam logic [4:0] SH_FLUSH  = 5'd24;

endpackage

/* sv/f2h_in_if.sv */
// Input channel of the converter: valid/ready with one binary32 pattern
// and a last flag. Depends on f2h_pkg.
interface f2h_in_if;
  logic                          valid;
  logic                          ready;
  logic [f2h_pkg::SGL_W-1:0]     single_bits;
  logic                          last_in;

  modport source (output valid, output single_bits, output last_in, input ready);
  modport sink   (input valid, input single_bits, input last_in, output ready);
endinterface

/* sv/f2h_out_if.sv */
// Output channel of the converter: valid/ready with one binary16 pattern
// and the passed-through last flag. Depends on f2h_pkg.
interface f2h_out_if;
  logic                          valid;
  logic                          ready;
  logic [f2h_pkg::HALF_W-1:0]    half_bits;
  logic                          last_out;

  modport source (output valid, output half_bits, output last_out, input ready);
  modport sink   (input valid, input half_bits, input last_out, output ready);
endinterface

/* sv/fp32_to_fp16_convert_rne.sv */
// Binary32 to binary16 conversion with round to nearest, ties to even.
// Throughput: one transfer per cycle; the three pipeline registers each stall
// only when they hold data that the stage after them cannot take.
// Reset: rst_ni clears the stage valid bits asynchronously; payload is not reset.
// Depends on f2h_pkg, f2h_in_if and f2h_out_if.
module fp32_to_fp16_convert_rne (
  input  logic         clk_i,
  input  logic         rst_ni,
  f2h_in_if.sink       in_i,
  f2h_out_if.source    out_o
);

  // Handshake chain. A stage may load when it is empty or when the stage
  // after it is loading too, so bubbles are squeezed out and the input
  // still takes a transfer while a finished result waits at the output.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  // ---------------------------------------------------------------------
  // Stage 1: decode the exponent into a half base value, the amount by
  // which the single fraction is shifted right, and whether rounding
  // applies. Large exponents and infinities never round; tiny values
  // below half of the smallest subnormal flush to a signed zero.
  // ---------------------------------------------------------------------
  logic [f2h_pkg::EXP_W-1:0]  exp_in;
  logic [f2h_pkg::FRAC_W-1:0] frac_in;
  logic [14:0]                base_d;
  logic [f2h_pkg::SH_W-1:0]   shift_d;
  logic                       rounds_d;
  logic                       nan_d;
  logic [3:0]                 sub_sh;

  logic                       sign1_q, rounds1_q, nan1_q, last1_q;
  logic [14:0]                base1_q;
  logic [f2h_pkg::SH_W-1:0]   shift1_q;
  logic [f2h_pkg::FRAC_W-1:0] frac1_q;

  assign exp_in  = in_i.single_bits[30:23];
  assign frac_in = in_i.single_bits[22:0];
  assign sub_sh  = 4'(f2h_pkg::SUB_SH_BASE - exp_in);

  always_comb begin
    base_d   = '0;
    shift_d  = f2h_pkg::SH_FLUSH;
    rounds_d = 1'b0;
    if (exp_in < f2h_pkg::EXP_SUB_LO) begin
      // Only the value just above half the smallest subnormal can round up.
      rounds_d = (exp_in == f2h_pkg::EXP_ROUND_ONLY);
    end else if (exp_in < f2h_pkg::EXP_NORM_LO) begin
      // Subnormal half: the hidden one lands inside the fraction field.
      base_d   = 15'(f2h_pkg::HALF_EXP_ONE >> sub_sh);
      shift_d  = 5'(f2h_pkg::SUB_FRAC_BASE - exp_in);
      rounds_d = 1'b1;
    end else if (exp_in <= f2h_pkg::EXP_NORM_HI) begin
      base_d   = {5'(exp_in - f2h_pkg::NORM_EXP_BIAS), 10'd0};
      shift_d  = f2h_pkg::SH_NORMAL;
      rounds_d = 1'b1;
    end else if (exp_in < f2h_pkg::EXP_SPECIAL) begin
      // Overflow saturates to infinity.
      base_d   = f2h_pkg::HALF_INF;
    end else begin
      // Infinity or NaN: keep the top ten fraction bits.
      base_d   = f2h_pkg::HALF_INF;
      shift_d  = f2h_pkg::SH_NORMAL;
    end
  end

  assign nan_d = (exp_in == f2h_pkg::EXP_SPECIAL) && (frac_in != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      sign1_q   <= in_i.single_bits[31];
      base1_q   <= base_d;
      shift1_q  <= shift_d;
      rounds1_q <= rounds_d;
      nan1_q    <= nan_d;
      frac1_q   <= frac_in;
      last1_q   <= in_i.last_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: align the fraction, and pick out the guard bit (the first bit
  // shifted out, or the hidden one when the whole fraction goes) and the
  // sticky bit (any lower bit set).
  // ---------------------------------------------------------------------
  logic [f2h_pkg::MAN_W-1:0]  man_d;
  logic [f2h_pkg::FRAC_W:0]   hid;
  logic [f2h_pkg::FRAC_W:0]   low_mask;
  logic [f2h_pkg::SH_W-1:0]   guard_pos;
  logic                       guard_d, sticky_d;

  logic [f2h_pkg::HALF_W-1:0] sb2_q;
  logic [f2h_pkg::MAN_W-1:0]  man2_q;
  logic                       guard2_q, sticky2_q, nan2_q, last2_q;

  assign guard_pos = shift1_q - 5'd1;
  assign man_d     = 10'(frac1_q >> shift1_q);
  assign hid       = {1'b1, frac1_q};
  assign low_mask  = (24'd1 << guard_pos) - 24'd1;
  assign guard_d   = rounds1_q && hid[guard_pos];
  assign sticky_d  = |(frac1_q & low_mask[f2h_pkg::FRAC_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sb2_q     <= {sign1_q, base1_q};
      man2_q    <= man_d;
      guard2_q  <= guard_d;
      sticky2_q <= sticky_d;
      nan2_q    <= nan1_q;
      last2_q   <= last1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: add the aligned fraction and the rounding increment to the
  // signed base. A carry out of the fraction moves into the exponent, which
  // is how a subnormal rounds to the smallest normal and the largest
  // finite value rounds to infinity. NaNs are forced quiet.
  // ---------------------------------------------------------------------
  logic                       lsb, inc;
  logic [f2h_pkg::HALF_W-1:0] sum;
  logic [f2h_pkg::HALF_W-1:0] half_d;
  logic [f2h_pkg::HALF_W-1:0] half3_q;
  logic                       last3_q;

  assign lsb    = sb2_q[0] ^ man2_q[0];
  assign inc    = guard2_q && (sticky2_q || lsb);
  assign sum    = sb2_q + {6'd0, man2_q} + {15'd0, inc};
  assign half_d = nan2_q ? (sum | f2h_pkg::HALF_QUIET) : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      half3_q <= half_d;
      last3_q <= last2_q;
    end
  end

  assign out_o.valid     = v3_q;
  assign out_o.half_bits = half3_q;
  assign out_o.last_out  = last3_q;

`ifndef NO_ASSERTIONS
  // A NaN leaving stage 2 always shows up as a quiet NaN at the output.
  a_nan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3 && nan2_q) |=>
      (out_o.half_bits[14:10] == 5'h1F && out_o.half_bits[9]))
    else $error("NaN input did not produce a quiet NaN");

  // Rounding never carries into the sign bit.
  a_sign_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> (out_o.half_bits[15] == $past(sb2_q[15])))
    else $error("rounding carry reached the sign bit");

  // With all stages full and the output stalled, no input is taken.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the pipeline was full and stalled");
`endif

endmodule
